// File: sv/cbot_pkg.sv
package cbot_pkg;

    localparam int SLOT_COUNT     = 12;
    localparam int SLOT_W         = 4;
    localparam int READING_W      = 14;
    localparam int MONTH_W        = 4;
    localparam int YEAR_W         = 10;
    localparam int INDEX_W        = 14;
    localparam int OFFSET_W       = 15;
    localparam int ACC_W          = 16;
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 16;

    localparam logic [SLOT_W-1:0] LAST_SLOT      = 4'd11;
    localparam logic [SLOT_W-1:0] MAX_SKIP_CLEAR = 4'd11;
    localparam logic [SLOT_W-1:0] MAX_WINDOW     = 4'd12;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRE   = 2'd3;

    localparam logic [CFG_W-1:0]  BASELINE_RESET  = 10'd421;
    localparam logic [CFG_W-1:0]  MIN_VALID_RESET = 10'd200;
    localparam logic [SLOT_W-1:0] LOOKBACK_RESET  = 4'd6;
    localparam logic [SLOT_W-1:0] REQUIRE_RESET   = 4'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CLEAR,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

// File: sv/co2_baseline_offset_tracker.sv
// channel  | dir | handshake             | payload (low bit up)
// ---------+-----+-----------------------+-------------------------------------------
// s_       | in  | s_tvalid / s_tready   | s_tdata: reading_ppm[13:0], month[17:14],
//          |     |                       |          year[27:18], zero fill [31:28]
// m_       | out | m_tvalid / m_tready   | m_tdata: offset_ppm[14:0], state_changed[15]
// cfg_     | in  | cfg_valid / cfg_ready | cfg_index: register, cfg_data: value
//
// each word steps through prepare, clearing of skipped slots (up to 11), a scan of up to 12
// slots by the shared compare, decide and output load; a low reading goes from prepare
// straight to output load; the sequencer then returns to idle
// reset is synchronous active low and restores slot ring, month index, accepted offset, config
// s_tready is high only while idle; a result waits in the output register while the next
// word is taken, and the sequencer stalls before its output load until that register is free
module co2_baseline_offset_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cbot_pkg::S_TDATA_W-1:0]     s_tdata,   // reading_ppm, month, year
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cbot_pkg::M_TDATA_W-1:0]     m_tdata,   // offset_ppm, state_changed
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbot_pkg::CFG_W-1:0]         cfg_data
);

    // config registers
    logic [cbot_pkg::CFG_W-1:0]  baseline_reg;
    logic [cbot_pkg::CFG_W-1:0]  min_valid_reg;
    logic [cbot_pkg::SLOT_W-1:0] lookback_reg;
    logic [cbot_pkg::SLOT_W-1:0] require_reg;

    // persistent tracker state
    logic [cbot_pkg::READING_W-1:0] slot_reg [cbot_pkg::SLOT_COUNT];
    logic [cbot_pkg::INDEX_W-1:0]   last_idx_reg;
    logic signed [cbot_pkg::ACC_W-1:0] acc_reg;

    // per-word working registers
    cbot_pkg::state_t state_reg, state_next;
    logic [cbot_pkg::READING_W-1:0] reading_reg;
    logic [cbot_pkg::INDEX_W-1:0]   idx_reg;
    logic [cbot_pkg::SLOT_W-1:0]    slot_sel_reg;
    logic [cbot_pkg::SLOT_W-1:0]    ptr_reg;
    logic [cbot_pkg::SLOT_W-1:0]    cnt_reg;
    logic [cbot_pkg::SLOT_W-1:0]    window_reg;
    logic [cbot_pkg::SLOT_W-1:0]    valid_cnt_reg;
    logic [cbot_pkg::READING_W-1:0] min_reg;
    logic                           changed_reg;
    logic signed [cbot_pkg::ACC_W-1:0] result_reg;

    // output register
    logic                            m_valid_reg;
    logic [cbot_pkg::M_TDATA_W-1:0]  m_data_reg;

    // input fields
    logic [cbot_pkg::READING_W-1:0] in_reading;
    logic [cbot_pkg::MONTH_W-1:0]   in_month;
    logic [cbot_pkg::YEAR_W-1:0]    in_year;
    logic [cbot_pkg::INDEX_W-1:0]   in_idx;
    logic [cbot_pkg::SLOT_W-1:0]    in_slot;

    logic accept;
    logic out_free;
    logic [cbot_pkg::INDEX_W-1:0]   gap;
    logic [cbot_pkg::SLOT_W-1:0]    clear_cnt;
    logic [cbot_pkg::SLOT_W-1:0]    window;
    logic [cbot_pkg::SLOT_W-1:0]    ptr_dec;
    logic [cbot_pkg::SLOT_W-1:0]    prev_slot;
    logic [cbot_pkg::READING_W-1:0] scan_val;
    logic signed [cbot_pkg::ACC_W-1:0] offset_new;
    logic adopt;

    assign in_reading = s_tdata[13:0];
    assign in_month   = s_tdata[17:14];
    assign in_year    = s_tdata[27:18];

    // year*12 + month as two shifted adds
    assign in_idx = ({1'b0, in_year, 3'b000} + {2'b00, in_year, 2'b00})
                  + {{(cbot_pkg::INDEX_W-cbot_pkg::MONTH_W){1'b0}}, in_month};
    // year*12 drops out of the mod, so only months past december wrap
    assign in_slot = (in_month > cbot_pkg::LAST_SLOT) ? (in_month - cbot_pkg::MAX_WINDOW)
                                                      : in_month;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign s_tready = (state_reg == cbot_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // months skipped between the last written month and this one, capped
    assign gap       = idx_reg - last_idx_reg - 14'd1;
    assign clear_cnt = (gap >= {10'd0, cbot_pkg::MAX_SKIP_CLEAR}) ? cbot_pkg::MAX_SKIP_CLEAR
                                                                : gap[3:0];
    assign window = (lookback_reg == 4'd0) ? 4'd1
                  : (lookback_reg > cbot_pkg::MAX_WINDOW) ? cbot_pkg::MAX_WINDOW
                  : lookback_reg;

    assign ptr_dec   = (ptr_reg == 4'd0) ? cbot_pkg::LAST_SLOT : ptr_reg - 4'd1;
    assign prev_slot = (slot_sel_reg == 4'd0) ? cbot_pkg::LAST_SLOT : slot_sel_reg - 4'd1;
    assign scan_val  = slot_reg[ptr_reg];

    assign offset_new = $signed({6'd0, baseline_reg}) - $signed({2'd0, min_reg});
    assign adopt = (offset_new > 0) || (offset_new > acc_reg) || (valid_cnt_reg >= require_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbot_pkg::ST_IDLE: begin
                if (accept) state_next = cbot_pkg::ST_PREP;
            end
            cbot_pkg::ST_PREP: begin
                if (reading_reg < {4'd0, min_valid_reg}) begin
                    state_next = cbot_pkg::ST_OUT;
                end else if (idx_reg > last_idx_reg && clear_cnt != 4'd0) begin
                    state_next = cbot_pkg::ST_CLEAR;
                end else begin
                    state_next = cbot_pkg::ST_SCAN;
                end
            end
            cbot_pkg::ST_CLEAR: begin
                if (cnt_reg == 4'd1) state_next = cbot_pkg::ST_SCAN;
            end
            cbot_pkg::ST_SCAN: begin
                if (cnt_reg == window_reg - 4'd1) state_next = cbot_pkg::ST_DECIDE;
            end
            cbot_pkg::ST_DECIDE: begin
                state_next = cbot_pkg::ST_OUT;
            end
            cbot_pkg::ST_OUT: begin
                if (out_free) state_next = cbot_pkg::ST_IDLE;
            end
            default: state_next = cbot_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbot_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg  <= cbot_pkg::BASELINE_RESET;
            min_valid_reg <= cbot_pkg::MIN_VALID_RESET;
            lookback_reg  <= cbot_pkg::LOOKBACK_RESET;
            require_reg   <= cbot_pkg::REQUIRE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cbot_pkg::REG_BASELINE:  baseline_reg  <= cfg_data;
                cbot_pkg::REG_MIN_VALID: min_valid_reg <= cfg_data;
                cbot_pkg::REG_LOOKBACK:  lookback_reg  <= cfg_data[3:0];
                cbot_pkg::REG_REQUIRE:   require_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // tracker state: slot ring, month index, accepted offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cbot_pkg::SLOT_COUNT; i++) slot_reg[i] <= '0;
            last_idx_reg <= '0;
            acc_reg      <= '0;
        end else begin
            case (state_reg)
                cbot_pkg::ST_PREP: begin
                    if (reading_reg >= {4'd0, min_valid_reg}) begin
                        if (idx_reg == last_idx_reg) begin
                            // same month: keep the lower reading
                            if (slot_reg[slot_sel_reg] > reading_reg)
                                slot_reg[slot_sel_reg] <= reading_reg;
                        end else begin
                            slot_reg[slot_sel_reg] <= reading_reg;
                            last_idx_reg <= idx_reg;
                        end
                    end
                end
                cbot_pkg::ST_CLEAR: begin
                    slot_reg[ptr_reg] <= '0;
                end
                cbot_pkg::ST_DECIDE: begin
                    if (valid_cnt_reg != 4'd0 && adopt) acc_reg <= offset_new;
                end
                default: ;
            endcase
        end
    end

    // working registers, payload only
    always_ff @(posedge aclk) begin
        case (state_reg)
            cbot_pkg::ST_IDLE: begin
                reading_reg  <= in_reading;
                idx_reg      <= in_idx;
                slot_sel_reg <= in_slot;
            end
            cbot_pkg::ST_PREP: begin
                window_reg    <= window;
                valid_cnt_reg <= '0;
                min_reg       <= '0;
                result_reg    <= acc_reg;
                changed_reg   <= 1'b0;
                if (reading_reg >= {4'd0, min_valid_reg}) begin
                    if (idx_reg == last_idx_reg) begin
                        changed_reg <= (slot_reg[slot_sel_reg] > reading_reg);
                    end else begin
                        changed_reg <= 1'b1;
                    end
                end
                if (idx_reg > last_idx_reg && clear_cnt != 4'd0) begin
                    // clear backward from the month before this one
                    ptr_reg <= prev_slot;
                    cnt_reg <= clear_cnt;
                end else begin
                    ptr_reg <= slot_sel_reg;
                    cnt_reg <= '0;
                end
            end
            cbot_pkg::ST_CLEAR: begin
                if (cnt_reg == 4'd1) begin
                    ptr_reg <= slot_sel_reg;
                    cnt_reg <= '0;
                end else begin
                    ptr_reg <= ptr_dec;
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
            cbot_pkg::ST_SCAN: begin
                // shared compare unit: running minimum over non-empty slots
                if (scan_val != '0) begin
                    if (valid_cnt_reg == 4'd0 || scan_val < min_reg) min_reg <= scan_val;
                    valid_cnt_reg <= valid_cnt_reg + 4'd1;
                end
                ptr_reg <= ptr_dec;
                cnt_reg <= cnt_reg + 4'd1;
            end
            cbot_pkg::ST_DECIDE: begin
                if (valid_cnt_reg != 4'd0 && adopt) begin
                    result_reg <= offset_new;
                    if (offset_new != acc_reg) changed_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == cbot_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cbot_pkg::ST_OUT && out_free) begin
            m_data_reg <= {changed_reg, result_reg[cbot_pkg::OFFSET_W-1:0]};
        end
    end

endmodule
